/* rtl/uripe_pkg.sv */
package uripe_pkg;

  // Register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0] REG_ESCAPE_MODE = 1'b0;  // word index, paddr[2]

  // Escape modes
  localparam logic [1:0] MODE_ENCODE_URI = 2'd0;
  localparam logic [1:0] MODE_IRI_TO_URI = 2'd1;
  localparam logic [1:0] MODE_HTML_URI   = 2'd2;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  // One run of source bytes caused by one input word, each raw or escaped
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      esc;
    logic [2:0]      cnt;      // 1..4 bytes in use
    logic            str_end;  // input word closed the string
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0, v};
    end else begin
      r = 8'h37 + {4'b0, v};
    end
    return r;
  endfunction

  function automatic logic is_unreserved(input logic [20:0] cp);
    return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
           (cp >= 21'h61 && cp <= 21'h7A) || cp == 21'h2D || cp == 21'h2E ||
           cp == 21'h5F || cp == 21'h7E;
  endfunction

  function automatic logic is_ucschar(input logic [20:0] cp);
    return (cp >= 21'hA0 && cp <= 21'hD7FF) ||
           (cp >= 21'hF900 && cp <= 21'hFDCF) ||
           (cp >= 21'hFDF0 && cp <= 21'hFFEF) ||
           (cp >= 21'h10000 && cp <= 21'hEFFFF && cp[15:0] <= 16'hFFFD);
  endfunction

  function automatic logic is_iprivate(input logic [20:0] cp);
    return (cp >= 21'hE000 && cp <= 21'hF8FF) ||
           (cp >= 21'hF0000 && cp <= 21'hFFFFD) ||
           (cp >= 21'h100000 && cp <= 21'h10FFFD);
  endfunction

  // Unused mode code falls back to encode-for-uri
  function automatic logic must_escape(input logic [1:0] mode, input logic [20:0] cp);
    logic r;
    case (mode)
      MODE_IRI_TO_URI: r = is_ucschar(cp) || is_iprivate(cp);
      MODE_HTML_URI:   r = !(cp >= 21'h20 && cp <= 21'h7E);
      default:         r = !is_unreserved(cp);
    endcase
    return r;
  endfunction

endpackage

/* rtl/uri_percent_escaper.sv */
// UTF-8 percent escaper. Bytes of a string enter on the s_ side, one per word;
// s_tlast marks the last byte of the string and flushes any unfinished
// character. A multi-byte character is held until complete, then sent on as
// its original bytes or as %XX escapes for each byte, per escape_mode
// (0 encode-for-uri, 1 iri-to-uri, 2 escape-html-uri, 3 acts as 0); malformed,
// overlong, surrogate, out-of-range and truncated sequences are always escaped
// byte by byte. On the m_ side, m_tuser[0] flags the last output word caused by
// one input word and m_tlast the last output word of the string. An input word
// is decoded in the cycle it is accepted and its whole output run (1 to 12
// words: one per raw byte, three per escaped byte, up to four source bytes) is
// loaded into one run register that a serializer drains at one word per cycle
// while m_tready is high; the next input word is accepted in the cycle the last
// word of the run leaves, so raw bytes pass at one input byte per cycle when
// the receiver does not stall, and an escaped byte is held until all of its
// words have left. A byte that only joins a pending character yields no output.
module uri_percent_escaper import uripe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input bytes
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] in_byte
  input  logic                  s_tlast,   // string_end
  // output bytes
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] out_byte
  output logic                  m_tlast,   // out_string_end
  output logic [0:0]            m_tuser    // [0] run_last
);

  logic [1:0]       escape_mode;
  logic [2:0][7:0]  pending_bytes;
  logic [1:0]       pending_count;
  logic [2:0]       expected_length;
  logic [20:0]      partial_codepoint;

  logic [1:0]       pending_count_next;
  logic [2:0]       expected_length_next;
  logic [20:0]      partial_codepoint_next;
  logic             pend_we;
  logic [1:0]       pend_wa;

  logic [7:0]       b;
  logic             cont;
  logic             joins;
  logic             lead_ok;
  logic [2:0]       join_cnt;
  logic [20:0]      cp_join;
  logic             cp_ok;
  logic             esc_all;
  logic             s_accept;
  logic             cfg_wr;
  run_t             run_d;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ESCAPE_MODE);
  assign prdata = (paddr[2] == REG_ESCAPE_MODE) ? {30'b0, escape_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= MODE_ENCODE_URI;
    end else if (cfg_wr) begin
      escape_mode <= pwdata[1:0];
    end
  end

  // Decode one input byte against the pending character
  always_comb begin
    b        = s_tdata;
    cont     = (b[7:6] == 2'b10);
    joins    = (pending_count != 2'd0) && cont;
    lead_ok  = (b >= 8'hC2) && (b <= 8'hF4);
    join_cnt = {1'b0, pending_count} + 3'd1;
    cp_join  = {partial_codepoint[14:0], b[5:0]};

    case (expected_length)
      3'd2:    cp_ok = cp_join >= 21'h80;
      3'd3:    cp_ok = (cp_join >= 21'h800) && !(cp_join >= 21'hD800 && cp_join <= 21'hDFFF);
      default: cp_ok = (cp_join >= 21'h10000) && (cp_join <= 21'h10FFFF);
    endcase
    esc_all = !cp_ok || must_escape(escape_mode, cp_join);

    for (int i = 0; i < 3; i++) begin
      run_d.bytes[i] = (pending_count == 2'(i)) ? b : pending_bytes[i];
    end
    run_d.bytes[3] = b;
    run_d.str_end  = s_tlast;
    run_d.esc      = 4'hF;
    run_d.cnt      = 3'd0;

    pending_count_next     = 2'd0;
    expected_length_next   = 3'd0;
    partial_codepoint_next = 21'd0;
    pend_we                = 1'b0;
    pend_wa                = 2'd0;

    if (joins) begin
      if (join_cnt >= expected_length) begin
        run_d.cnt = join_cnt;
        run_d.esc = {4{esc_all}};
      end else if (s_tlast) begin
        run_d.cnt = join_cnt;
      end else begin
        pend_we                = 1'b1;
        pend_wa                = pending_count;
        pending_count_next     = join_cnt[1:0];
        expected_length_next   = expected_length;
        partial_codepoint_next = cp_join;
      end
    end else begin
      // pending bytes (if any) are flushed escaped ahead of this byte
      run_d.cnt = {1'b0, pending_count} + 3'd1;
      if (!b[7]) begin
        run_d.esc[pending_count] = must_escape(escape_mode, {13'b0, b});
      end else if (lead_ok && !s_tlast) begin
        run_d.cnt          = {1'b0, pending_count};
        pend_we            = 1'b1;
        pending_count_next = 2'd1;
        if (b <= 8'hDF) begin
          expected_length_next   = 3'd2;
          partial_codepoint_next = {16'b0, b[4:0]};
        end else if (b <= 8'hEF) begin
          expected_length_next   = 3'd3;
          partial_codepoint_next = {17'b0, b[3:0]};
        end else begin
          expected_length_next   = 3'd4;
          partial_codepoint_next = {18'b0, b[2:0]};
        end
      end
    end
  end

  assign s_accept = s_tvalid && s_tready;

  // Character assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count     <= 2'd0;
      expected_length   <= 3'd0;
      partial_codepoint <= 21'd0;
    end else if (s_accept) begin
      pending_count     <= pending_count_next;
      expected_length   <= expected_length_next;
      partial_codepoint <= partial_codepoint_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && pend_we) begin
      pending_bytes[pend_wa] <= b;
    end
  end

  uripe_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (s_accept && (run_d.cnt != 3'd0)),
    .run_in   (run_d),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_pending_short: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> ({1'b0, pending_count} < expected_length))
    else $error("pending character already complete");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (pending_count == 2'd0) |-> (partial_codepoint == 21'd0 && expected_length == 3'd0))
    else $error("stale decode state with nothing pending");
  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> (pending_count == 2'd0))
    else $error("bytes left pending after end of string");
`endif

endmodule

/* rtl/uripe_emitter.sv */
module uripe_emitter import uripe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  run_t       run_in,
  output logic       in_ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // out_string_end
  output logic [0:0] m_tuser    // [0] run_last
);

  run_t       run;
  logic       run_valid;
  logic [1:0] idx;
  logic [1:0] phase;   // 0: '%' or raw byte, 1: high digit, 2: low digit

  logic [7:0] cur;
  logic       cur_esc;
  logic       byte_last;
  logic       run_end;
  logic       fire;
  logic       done;

  // Output word from the run register
  always_comb begin
    cur       = run.bytes[idx];
    cur_esc   = run.esc[idx];
    byte_last = !cur_esc || (phase == 2'd2);
    run_end   = byte_last && ({1'b0, idx} == run.cnt - 3'd1);
    case (phase)
      2'd0:    m_tdata = cur_esc ? CHAR_PERCENT : cur;
      2'd1:    m_tdata = hex_digit(cur[7:4]);
      default: m_tdata = hex_digit(cur[3:0]);
    endcase
  end

  assign m_tvalid   = run_valid;
  assign m_tuser[0] = run_end;
  assign m_tlast    = run_end && run.str_end;
  assign fire       = run_valid && m_tready;
  assign done       = fire && run_end;
  assign in_ready   = !run_valid || done;

  // Run register and serializer position
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 2'd0;
      phase     <= 2'd0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= 2'd0;
      phase     <= 2'd0;
    end else if (done) begin
      run_valid <= 1'b0;
    end else if (fire) begin
      if (byte_last) begin
        idx   <= idx + 2'd1;
        phase <= 2'd0;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> ({1'b0, idx} < run.cnt))
    else $error("serializer index beyond run length");
  a_digit_only_escaped: assert property (@(posedge clk) disable iff (rst)
    (run_valid && phase != 2'd0) |-> cur_esc)
    else $error("hex digit phase on a raw byte");
  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    load |=> (run_valid && idx == 2'd0 && phase == 2'd0))
    else $error("new run did not start at its first byte");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> in_ready)
    else $error("run loaded over an unfinished run");
`endif

endmodule

/* bench/uri_percent_escaper_test.sv */
module uri_percent_escaper_test;
  import uripe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // decodes as encode-for-uri
  localparam int STALL_LIMIT = 2000;           // cycles with no handshake at all
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_SETTLE = 8;

  // One output word as the block should produce it
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } esc_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] in_byte
  logic                  s_tlast = 1'b0; // string_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // [7:0] out_byte
  logic                  m_tlast;        // out_string_end
  logic [0:0]            m_tuser;        // [0] run_last

  uri_percent_escaper u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Expected output text and bookkeeping
  esc_word_t expected_text[$];
  esc_word_t step_words[$];
  int        fail_count = 0;
  int        bytes_sent = 0;
  int        words_seen = 0;
  int        mode_writes = 0;
  int        idle_cycles = 0;
  bit        tx_jitter = 1'b0;
  bit        rx_jitter = 1'b0;
  int        rx_hold_left = 0;
  int        rx_gap_left = 0;

  // Escaper state as the bench sees it
  logic [1:0]  cur_mode = MODE_ENCODE_URI;
  logic [7:0]  char_buf [4];
  logic [2:0]  char_fill = '0;
  logic [2:0]  char_len = '0;
  logic [20:0] char_cp = '0;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v > 4'd9) begin
      return 8'h41 + {4'b0, v} - 8'd10;
    end
    return 8'h30 + {4'b0, v};
  endfunction

  // Does this code point get percent-escaped in the given mode
  function automatic logic escape_needed(input logic [1:0] mode, input logic [20:0] cp);
    logic r;
    case (mode)
      MODE_IRI_TO_URI: begin
        // ucschar plus private use; supplementary planes stop at xFFFD
        r = (cp >= 21'hA0 && cp <= 21'hD7FF) || (cp >= 21'hE000 && cp <= 21'hFDCF) ||
            (cp >= 21'hFDF0 && cp <= 21'hFFEF) ||
            (cp >= 21'h10000 && cp <= 21'h10FFFF && cp[15:0] <= 16'hFFFD);
      end
      MODE_HTML_URI: begin
        r = cp < 21'h20 || cp > 21'h7E;
      end
      default: begin
        r = 1'b1;
        if (cp < 21'h80) begin
          if ((cp[6:0] >= 7'h30 && cp[6:0] <= 7'h39) ||
              (cp[6:0] >= 7'h41 && cp[6:0] <= 7'h5A) ||
              (cp[6:0] >= 7'h61 && cp[6:0] <= 7'h7A) ||
              cp[6:0] == 7'h2D || cp[6:0] == 7'h2E || cp[6:0] == 7'h5F || cp[6:0] == 7'h7E)
            r = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void emit(input logic [7:0] c);
    esc_word_t w;
    w.data = c;
    w.run_last = 1'b0;
    w.str_end = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void emit_pct(input logic [7:0] b);
    emit(CHAR_PERCENT);
    emit(hex_char(b[7:4]));
    emit(hex_char(b[3:0]));
  endfunction

  function automatic void drop_held();
    char_fill = '0;
    char_len = '0;
    char_cp = '0;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < char_fill; i++) emit_pct(char_buf[i]);
    drop_held();
  endfunction

  function automatic logic cp_legal();
    case (char_len)
      3'd2: return char_cp >= 21'h80;
      3'd3: return char_cp >= 21'h800 && !(char_cp >= 21'hD800 && char_cp <= 21'hDFFF);
      default: return char_cp >= 21'h10000 && char_cp <= 21'h10FFFF;
    endcase
  endfunction

  // Work out the output words caused by one accepted input byte
  function automatic void predict_output(input logic [7:0] b, input logic last);
    esc_word_t w;
    step_words.delete();
    // a non-continuation byte breaks off the held character
    if (char_fill != 0 && b[7:6] != 2'b10) flush_held();
    if (char_fill != 0) begin
      char_buf[char_fill[1:0]] = b;
      char_fill = char_fill + 3'd1;
      char_cp = {char_cp[14:0], b[5:0]};
      if (char_fill >= char_len) begin
        if (!cp_legal() || escape_needed(cur_mode, char_cp)) begin
          flush_held();
        end else begin
          for (int i = 0; i < char_fill; i++) emit(char_buf[i]);
          drop_held();
        end
      end
    end else if (!b[7]) begin
      if (escape_needed(cur_mode, {13'b0, b})) emit_pct(b);
      else emit(b);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      char_buf[0] = b;
      char_fill = 3'd1;
      if (b < 8'hE0) begin
        char_len = 3'd2;
        char_cp = {16'b0, b[4:0]};
      end else if (b < 8'hF0) begin
        char_len = 3'd3;
        char_cp = {17'b0, b[3:0]};
      end else begin
        char_len = 3'd4;
        char_cp = {18'b0, b[2:0]};
      end
    end else begin
      // stray continuation or a lead that can never be legal
      emit_pct(b);
    end
    // truncated at end of string
    if (last && char_fill != 0) flush_held();
    if (step_words.size() != 0) begin
      w = step_words[$];
      w.run_last = 1'b1;
      w.str_end = last;
      step_words[$] = w;
    end
    foreach (step_words[i]) expected_text.insert(expected_text.size(), step_words[i]);
  endfunction

  // Predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin : monitor
    esc_word_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_output(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_text.size() == 0) begin
          $error("output word %02h with nothing expected", m_tdata);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
            fail_count++;
          end
          if (m_tuser[0] !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, m_tuser[0]);
            fail_count++;
          end
          if (m_tlast !== want.str_end) begin
            $error("out_string_end: expected %0b, got %0b", want.str_end, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else if (rx_jitter && $urandom_range(0, 9) == 0) begin
      rx_gap_left = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one byte and wait until it is taken; call right after a rising edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_jitter && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    // a byte that only joins a character may still be in flight
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Write escape_mode over APB, then read it back
  task automatic set_mode(input logic [1:0] m);
    drain_outputs();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ESCAPE_MODE, 2'b00};
    pwdata <= {30'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cur_mode = m;
    mode_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== m) begin
      $error("escape_mode: expected %0d, got %0d", m, prdata[1:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int len, input int idx);
    logic [20:0] part;
    if (idx == 0) begin
      case (len)
        1: return cp[7:0];
        2: return {3'b110, cp[10:6]};
        3: return {4'b1110, cp[15:12]};
        default: return {5'b11110, cp[20:18]};
      endcase
    end
    part = cp >> (6 * (len - 1 - idx));
    return {2'b10, part[5:0]};
  endfunction

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [20:0] random_cp(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: cp = 21'($urandom_range('h800, 'hFFFF));
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Code points on the edges of the class ranges of all modes
  function automatic logic [20:0] edge_cp(input int i);
    case (i)
      0: return 21'h00;       1: return 21'h1F;       2: return 21'h20;
      3: return 21'h2C;       4: return 21'h2D;       5: return 21'h2E;
      6: return 21'h2F;       7: return 21'h30;       8: return 21'h39;
      9: return 21'h3A;       10: return 21'h40;      11: return 21'h41;
      12: return 21'h5A;      13: return 21'h5B;      14: return 21'h5E;
      15: return 21'h5F;      16: return 21'h60;      17: return 21'h61;
      18: return 21'h7A;      19: return 21'h7B;      20: return 21'h7D;
      21: return 21'h7E;      22: return 21'h7F;      23: return 21'h80;
      24: return 21'h9F;      25: return 21'hA0;      26: return 21'h7FF;
      27: return 21'h800;     28: return 21'hD7FF;    29: return 21'hE000;
      30: return 21'hF8FF;    31: return 21'hF900;    32: return 21'hFDCF;
      33: return 21'hFDD0;    34: return 21'hFDEF;    35: return 21'hFDF0;
      36: return 21'hFFEF;    37: return 21'hFFF0;    38: return 21'hFFFF;
      39: return 21'h10000;   40: return 21'h1FFFD;   41: return 21'h1FFFE;
      42: return 21'hEFFFF;   43: return 21'hF0000;   44: return 21'hFFFFD;
      45: return 21'hFFFFE;   46: return 21'h100000;  47: return 21'h10FFFD;
      48: return 21'h10FFFE;  default: return 21'h10FFFF;
    endcase
  endfunction

  // One random character: mostly well formed, some noise and broken sequences
  task automatic send_char();
    int          pick;
    int          len;
    int          nb;
    int          r;
    logic [20:0] cp;
    logic        stop;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      cp = 21'($urandom_range(0, 255));
      len = 1;
    end else if (pick < 35) begin
      cp = edge_cp($urandom_range(0, 49));
      len = natural_len(cp);
    end else if (pick < 75) begin
      r = $urandom_range(0, 9);
      len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : 4;
      cp = random_cp(len);
    end else if (pick < 85) begin
      len = $urandom_range(2, 4);
      cp = random_cp(len);
    end else if (pick < 90) begin
      // overlong form
      len = $urandom_range(2, 4);
      cp = random_cp(len - 1);
    end else if (pick < 95) begin
      len = 3;
      cp = 21'($urandom_range('hD800, 'hDFFF));
    end else begin
      len = 4;
      cp = 21'($urandom_range('h110000, 'h1FFFFF));
    end
    nb = (pick >= 75 && pick < 85) ? $urandom_range(1, len - 1) : len;
    stop = ($urandom_range(0, 11) == 0);
    for (int k = 0; k < nb; k++) send_byte(utf8_byte(cp, len, k), stop && k == nb - 1);
  endtask

  // Field extremes, stray and invalid leads, broken and illegal sequences
  task automatic test_directed();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    send_byte(8'h41, 1'b0); send_byte(8'h7E, 1'b0); send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'hC0, 1'b0); send_byte(8'hC1, 1'b0);
    send_byte(8'hF5, 1'b0);
    // complete two-byte character
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    // lead interrupted by ASCII
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
    // overlong, surrogate, above U+10FFFF
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // lead alone gives nothing, then the string ends mid-character
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
  endtask

  // Receiver holds off while escaped bytes keep arriving
  task automatic test_holdoff();
    drain_outputs();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    rx_hold_left = HOLDOFF_CYCLES;
    for (int i = 0; i < 30; i++) send_byte(i[7:0], i == 29);
    drain_outputs();
  endtask

  task automatic test_random_phase(input logic [1:0] mode, input int n, input bit txj,
                                   input bit rxj);
    int target;
    set_mode(mode);
    tx_jitter = txj;
    rx_jitter = rxj;
    target = bytes_sent + n;
    while (bytes_sent < target) send_char();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_mode(MODE_ENCODE_URI);
    test_directed();
    test_holdoff();
    test_random_phase(MODE_IRI_TO_URI, 90, 1'b1, 1'b1);
    test_random_phase(MODE_HTML_URI, 90, 1'b1, 1'b0);
    test_random_phase(MODE_UNUSED, 90, 1'b0, 1'b1);
    test_random_phase(MODE_ENCODE_URI, 90, 1'b1, 1'b1);
    // closing stretch runs without idling
    test_random_phase(MODE_HTML_URI, 90, 1'b0, 1'b0);
    drain_outputs();
    repeat (16) @(posedge clk);
    $display("Run covered %0d input bytes under %0d mode settings (codes 0 to 3),",
             bytes_sent, mode_writes);
    $display("one long receiver hold-off, %0d output words compared, %0d mismatches.",
             words_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
